@@ hw/rtl/rgbblend_pkg.sv @@
// Shared beat types and channel constants for the RGBA8888-over-RGB565 blender.
package rgbblend_pkg;

    // Input beat: RGBA8888 source pixel and the RGB565 pixel under it
    typedef struct packed {
        logic [31:0] source_pixel;
        logic [15:0] dest_pixel;
    } src_beat_t;

    // Result beat: new RGB565 color and its write enable
    typedef struct packed {
        logic [15:0] blended_pixel;
        logic        write_enable;
    } res_beat_t;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [7:0] ALPHA_HALF   = 8'd127;
    localparam logic [4:0] CH5_MAX      = 5'h1F;
    localparam logic [5:0] CH6_MAX      = 6'h3F;

endpackage

@@ hw/rtl/rgba8888_over_rgb565_blend.sv @@
// RGBA8888-over-RGB565 alpha blender, three-stage pipeline, one pixel per cycle.
//
// Input channel s_*: one beat carries a source pixel (RGBA8888) and the
// destination pixel (RGB565) beneath it. Result channel m_*: one beat per
// input beat, in order, with the blended RGB565 color and a write enable
// that is low when the effective alpha is zero (color then equals the
// destination). cfg_wr_en/cfg_wr_data set hard-alpha mode, which forces
// alpha to 0 or 255 around 127; write it only while the pipeline is empty.
//
// Path: an accepted beat passes the product stage, the sum stage and the
// divide-by-255 into the output register, where m_valid rises for it.
// Throughput: one beat per cycle while m_ready is high; every stage has
// its own valid bit and moves whenever the stage after it is empty or
// moving, so bubbles collapse.
// When the receiver stalls, the output register holds its beat and the
// stages behind it fill up; s_ready drops only when all three stages are
// full and m_ready is low.
// Reset (aresetn low at a clock edge) empties the pipeline and clears
// hard-alpha mode.
module rgba8888_over_rgb565_blend
    import rgbblend_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  src_beat_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output res_beat_t m_data
);

    // Configuration
    logic hard_alpha_reg;

    // Stage 1: cut source, effective alpha, per-channel products
    logic        v1_reg;
    logic        copy1_reg;
    logic        skip1_reg;
    logic [15:0] dst1_reg;
    logic [15:0] src1_reg;
    logic [7:0]  alpha1_reg;
    logic [12:0] pr_s_reg, pr_d_reg, pb_s_reg, pb_d_reg;
    logic [13:0] pg_s_reg, pg_d_reg;

    // Stage 2: weighted sums
    logic        v2_reg;
    logic        copy2_reg;
    logic        skip2_reg;
    logic [15:0] dst2_reg;
    logic [15:0] src2_reg;
    logic [13:0] sum_r_reg, sum_b_reg;
    logic [14:0] sum_g_reg;

    // Stage 3: output register
    logic      v3_reg;
    res_beat_t out_reg;

    logic stg1_rdy, stg2_rdy, stg3_rdy;

    // Stage-1 combinational decode
    logic [4:0] sr_w, sb_w, dr_w, db_w;
    logic [5:0] sg_w, dg_w;
    logic [7:0] a_raw_w, a_eff_w, a_inv_w;

    // Stage-3 combinational divide by 255
    logic [14:0] qr_w, qb_w;
    logic [15:0] qg_w;
    logic [4:0]  rr_w, rb_w;
    logic [5:0]  rg_w;
    res_beat_t   out_next;

    // Hand-off: a stage loads when it is empty or its content moves on
    assign stg3_rdy = !v3_reg || m_ready;
    assign stg2_rdy = !v2_reg || stg3_rdy;
    assign stg1_rdy = !v1_reg || stg2_rdy;
    assign s_ready  = stg1_rdy;

    // Decode the input beat
    always_comb begin
        sr_w    = s_data.source_pixel[31:27];
        sg_w    = s_data.source_pixel[23:18];
        sb_w    = s_data.source_pixel[15:11];
        a_raw_w = s_data.source_pixel[7:0];
        dr_w    = s_data.dest_pixel[15:11];
        dg_w    = s_data.dest_pixel[10:5];
        db_w    = s_data.dest_pixel[4:0];
        if (hard_alpha_reg) begin
            a_eff_w = (a_raw_w > ALPHA_HALF) ? ALPHA_OPAQUE : ALPHA_CLEAR;
        end else begin
            a_eff_w = a_raw_w;
        end
        a_inv_w = ALPHA_OPAQUE - a_eff_w;
    end

    // Divide each sum by 255: floor(x/255) = (x + (x >> 8) + 1) >> 8 below 65535
    always_comb begin
        qr_w = ({1'b0, sum_r_reg} + {9'd0, sum_r_reg[13:8]} + 15'd1) >> 8;
        qg_w = ({1'b0, sum_g_reg} + {9'd0, sum_g_reg[14:8]} + 16'd1) >> 8;
        qb_w = ({1'b0, sum_b_reg} + {9'd0, sum_b_reg[13:8]} + 15'd1) >> 8;
        rr_w = (qr_w > {10'd0, CH5_MAX}) ? CH5_MAX : qr_w[4:0];
        rg_w = (qg_w > {10'd0, CH6_MAX}) ? CH6_MAX : qg_w[5:0];
        rb_w = (qb_w > {10'd0, CH5_MAX}) ? CH5_MAX : qb_w[4:0];
        if (skip2_reg) begin
            out_next.blended_pixel = dst2_reg;
            out_next.write_enable  = 1'b0;
        end else if (copy2_reg) begin
            out_next.blended_pixel = src2_reg;
            out_next.write_enable  = 1'b1;
        end else begin
            out_next.blended_pixel = {rr_w, rg_w, rb_w};
            out_next.write_enable  = 1'b1;
        end
    end

    // Control: config register and stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hard_alpha_reg <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hard_alpha_reg <= cfg_wr_data;
            end
            if (stg1_rdy) begin
                v1_reg <= s_valid;
            end
            if (stg2_rdy) begin
                v2_reg <= v1_reg;
            end
            if (stg3_rdy) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload: advance each stage on its load enable
    always_ff @(posedge aclk) begin
        if (stg1_rdy) begin
            copy1_reg  <= (a_eff_w == ALPHA_OPAQUE);
            skip1_reg  <= (a_eff_w == ALPHA_CLEAR);
            dst1_reg   <= s_data.dest_pixel;
            src1_reg   <= {sr_w, sg_w, sb_w};
            alpha1_reg <= a_eff_w;
            pr_s_reg   <= {8'd0, sr_w} * {5'd0, a_eff_w};
            pr_d_reg   <= {8'd0, dr_w} * {5'd0, a_inv_w};
            pg_s_reg   <= {8'd0, sg_w} * {6'd0, a_eff_w};
            pg_d_reg   <= {8'd0, dg_w} * {6'd0, a_inv_w};
            pb_s_reg   <= {8'd0, sb_w} * {5'd0, a_eff_w};
            pb_d_reg   <= {8'd0, db_w} * {5'd0, a_inv_w};
        end
        if (stg2_rdy) begin
            copy2_reg <= copy1_reg;
            skip2_reg <= skip1_reg;
            dst2_reg  <= dst1_reg;
            src2_reg  <= src1_reg;
            sum_r_reg <= {1'b0, pr_s_reg} + {1'b0, pr_d_reg};
            sum_g_reg <= {1'b0, pg_s_reg} + {1'b0, pg_d_reg};
            sum_b_reg <= {1'b0, pb_s_reg} + {1'b0, pb_d_reg};
        end
        if (stg3_rdy) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = v3_reg;
    assign m_data  = out_reg;

    // Input back-pressure only when every stage is full and the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && !m_ready))
        else $error("s_ready low with room in the pipeline");

    // Hard-alpha mode leaves only fully clear or fully opaque alpha
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && hard_alpha_reg) |-> (alpha1_reg == ALPHA_CLEAR || alpha1_reg == ALPHA_OPAQUE))
        else $error("hard-alpha mode produced a partial alpha");

    // Blended channels never exceed their maxima
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !copy2_reg && !skip2_reg) |->
            (qr_w <= {10'd0, CH5_MAX} && qg_w <= {10'd0, CH6_MAX} && qb_w <= {10'd0, CH5_MAX}))
        else $error("divide-by-255 result out of channel range");

endmodule
